/* hdl/ssearch_pkg.sv */
// Shared types and constants for the streaming substring search block.
`timescale 1ns / 1ps

package ssearch_pkg;

    localparam int NEEDLE_BYTES = 16;
    localparam int LEN_W        = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int OFF_OUT_W    = 32;
    localparam int BYTE_W       = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN   = 2'd2;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle;
        logic [LEN_W-1:0]                    length;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [OFF_OUT_W-1:0] offset;
    } result_t;

endpackage

/* hdl/streaming_substring_search.sv */
// Top level of the streaming substring search: input register, core and result register.
//
// Channel   Dir  tdata bits (low up)     tuser bits          Meaning
// s_axis    in   [7:0] data_byte         [0] kind            haystack byte or end marker
// m_axis    out  [31:0] match_offset     [0] found           one result per haystack
// cfg       in   cfg_data[63:0]          cfg_index[1:0]      needle bytes and length
//
// One item is taken per clock unless m_axis stalls; its result comes via both registers.
// The needle compare is combinational between the input and result registers.
// A stall on m_axis holds the result register and stops input once the input register fills.
// Reset clears the counters, the handshake state and the needle to length one, all zero.
`timescale 1ns / 1ps

module streaming_substring_search
    import ssearch_pkg::*;
#(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OFF_OUT_W-1:0]  m_axis_tdata,   // [31:0] match_offset
    output logic                  m_axis_tuser,   // [0] found
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    result_t           res;
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [OFF_OUT_W-1:0] out_offset_reg;
    logic              step;

    // The held item is processed whenever the result register can take a result.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    ssearch_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssearch_core #(
        .MAX_NEEDLE  (MAX_NEEDLE),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .kind      (in_kind_reg),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (step && res.valid)
        begin
            out_found_reg  <= res.found;
            out_offset_reg <= res.offset;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_offset_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

/* hdl/ssearch_cfg_regs.sv */
// Configuration registers holding the needle bytes and the needle length.
`timescale 1ns / 1ps

module ssearch_cfg_regs
    import ssearch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEEDLE_FIRST: cfg_next.needle[7:0]  = cfg_data;
                CFG_NEEDLE_LAST:  cfg_next.needle[15:8] = cfg_data;
                CFG_NEEDLE_LEN:   cfg_next.length       = cfg_data[LEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.needle <= '0;
            cfg_reg.length <= LEN_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/ssearch_core.sv */
// Sliding byte window, haystack counters and the parallel needle compare.
`timescale 1ns / 1ps

module ssearch_core
    import ssearch_pkg::*;
#(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              kind,
    input  logic [BYTE_W-1:0] data_byte,
    input  cfg_t              cfg,
    output result_t           res
);

    localparam int SEEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int IDX_W  = $clog2(MAX_NEEDLE);
    localparam logic [LEN_W-1:0]       MAX_LEN  = LEN_W'(MAX_NEEDLE);
    localparam logic [SEEN_W-1:0]      SEEN_MAX = SEEN_W'(MAX_NEEDLE);
    localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;

    logic [BYTE_W-1:0]      window_reg [MAX_NEEDLE];
    logic [BYTE_W-1:0]      window_next [MAX_NEEDLE];
    logic [BYTE_W-1:0]      win_shift [MAX_NEEDLE];
    logic [SEEN_W-1:0]      seen_reg, seen_next, seen_inc;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_inc, off_full;
    logic                   done_reg, done_next;
    logic [LEN_W-1:0]       len_used;
    logic                   match;

    assign len_used = (cfg.length > MAX_LEN) ? MAX_LEN : cfg.length;
    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_W'(1);
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
    // The match starts len - 1 bytes before the byte that completes it.
    assign off_full = pos_reg - OFFSET_BITS'(len_used) + OFFSET_BITS'(1);

    always_comb
    begin
        win_shift[0] = data_byte;
        for (int i = 1; i < MAX_NEEDLE; i++)
        begin
            win_shift[i] = window_reg[i-1];
        end
    end

    // Needle byte i sits len - 1 - i places behind the newest window byte.
    always_comb
    begin
        logic [LEN_W-1:0] diff;
        diff  = '0;
        match = 1'b1;
        for (int i = 0; i < MAX_NEEDLE; i++)
        begin
            if (LEN_W'(i) < len_used)
            begin
                diff = len_used - LEN_W'(i) - LEN_W'(1);
                if (win_shift[diff[IDX_W-1:0]] != cfg.needle[i])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        pos_next    = pos_reg;
        done_next   = done_reg;
        res         = '0;
        if (step)
        begin
            if (kind == KIND_END)
            begin
                res.valid = !done_reg;
                res.found = (len_used == '0);
                seen_next = '0;
                pos_next  = '0;
                done_next = 1'b0;
            end
            else if (!done_reg)
            begin
                window_next = win_shift;
                seen_next   = seen_inc;
                pos_next    = pos_inc;
                if (len_used == '0)
                begin
                    done_next = 1'b1;
                    res.valid = 1'b1;
                    res.found = 1'b1;
                end
                else if ((LEN_W'(seen_inc) >= len_used) && match)
                begin
                    done_next  = 1'b1;
                    res.valid  = 1'b1;
                    res.found  = 1'b1;
                    res.offset = OFF_OUT_W'(off_full);
                end
            end
        end
    end

    // Window bytes past the fill count are never compared, so they need no reset.
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

endmodule

/* hdl/ssearch_checker.sv */
// Port-level checks for the streaming substring search, bound to the top level.
`timescale 1ns / 1ps

module ssearch_checker
    import ssearch_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [BYTE_W-1:0]     s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OFF_OUT_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A not-found result always carries offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero offset");

    // With the result register empty, the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // The input side stalls only behind a result that is waiting to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no waiting result");

    // A waiting input transfer keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input changed while waiting");

endmodule

bind streaming_substring_search ssearch_checker u_ssearch_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
